// ===== src/aes_cbc_pkg.sv =====
// Shared types, constants and round functions of the AES-CBC block.
// Used by the controller, the datapath and the top level.
`default_nettype none

package aes_cbc_pkg;

	// Size of the key schedule store, in 32-bit schedule words (44..60).
	localparam int SCHEDULE_WORDS = 60;
	localparam int RK_ROWS = SCHEDULE_WORDS / 4;
	localparam int RK_AW = (RK_ROWS > 1) ? $clog2(RK_ROWS) : 1;
	localparam int NK_MAX = (SCHEDULE_WORDS >= 60) ? 8 : ((SCHEDULE_WORDS >= 52) ? 6 : 4);

	// Configuration register indexes.
	localparam logic [2:0] REG_KEY_0 = 3'd0;
	localparam logic [2:0] REG_KEY_1 = 3'd1;
	localparam logic [2:0] REG_KEY_2 = 3'd2;
	localparam logic [2:0] REG_KEY_3 = 3'd3;
	localparam logic [2:0] REG_KEY_LEN = 3'd4;
	localparam logic [2:0] REG_IV_HIGH = 3'd5;
	localparam logic [2:0] REG_IV_LOW = 3'd6;
	localparam logic [2:0] REG_DECRYPT_MODE = 3'd7;

	localparam logic [1:0] KEY_LEN_128 = 2'd0;
	localparam logic [1:0] KEY_LEN_192 = 2'd1;

	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] GF_POLY = 8'h1b;

	// Datapath operation codes.
	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_ARK = 2'd1;
	localparam logic [1:0] OP_ROUND = 2'd2;

	localparam logic [2047:0] FWD_BOX_BITS = {
		128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
		128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
		128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
		128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
		128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
		128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
		128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
		128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

	localparam logic [2047:0] INV_BOX_BITS = {
		128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
		128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
		128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
		128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
		128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
		128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
		128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
		128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

	// Controller to datapath commands.
	typedef struct packed {
		logic accept;
		logic exp_en;
		logic exp_from_key;
		logic [5:0] exp_idx;
		logic exp_rot;
		logic exp_sub;
		logic load;
		logic [1:0] op;
		logic last;
		logic finish;
		logic [RK_AW-1:0] rd_addr;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic [3:0] nk;
		logic [3:0] nr;
		logic decrypt;
		logic key_change;
	} status_t;

	function automatic logic [7:0] fwd_box(input logic [7:0] x);
		return FWD_BOX_BITS[{~x, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] inv_box(input logic [7:0] x);
		return INV_BOX_BITS[{~x, 3'b000} +: 8];
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		return {fwd_box(w[31:24]), fwd_box(w[23:16]), fwd_box(w[15:8]), fwd_box(w[7:0])};
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
	endfunction

	// Effective words per key, limited to what the schedule store can hold.
	function automatic logic [3:0] eff_nk(input logic [1:0] ks);
		logic [3:0] nk;
		if (ks == KEY_LEN_128) nk = 4'd4;
		else if (ks == KEY_LEN_192) nk = 4'd6;
		else nk = 4'd8;
		if (nk > 4'(NK_MAX)) nk = 4'(NK_MAX);
		return nk;
	endfunction

	// Byte n of the block sits at bits 127-8n down.
	function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		int fs;
		int is;
		int d;
		t = '0;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				d = r + 4 * c;
				fs = r + 4 * ((c + r) & 3);
				is = r + 4 * ((c + 4 - r) & 3);
				if (inv) t[127 - 8 * d -: 8] = inv_box(s[127 - 8 * is -: 8]);
				else t[127 - 8 * d -: 8] = fwd_box(s[127 - 8 * fs -: 8]);
			end
		end
		return t;
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [31:0] o;
		o = '0;
		for (int k = 0; k < 4; k++) begin
			a[k] = col[31 - 8 * k -: 8];
			x2[k] = xt(a[k]);
			x4[k] = xt(x2[k]);
			x8[k] = xt(x4[k]);
		end
		for (int r = 0; r < 4; r++) begin
			if (inv) begin
				o[31 - 8 * r -: 8] = (x8[r] ^ x4[r] ^ x2[r])
					^ (x8[(r + 1) & 3] ^ x2[(r + 1) & 3] ^ a[(r + 1) & 3])
					^ (x8[(r + 2) & 3] ^ x4[(r + 2) & 3] ^ a[(r + 2) & 3])
					^ (x8[(r + 3) & 3] ^ a[(r + 3) & 3]);
			end else begin
				o[31 - 8 * r -: 8] = x2[r] ^ (x2[(r + 1) & 3] ^ a[(r + 1) & 3])
					^ a[(r + 2) & 3] ^ a[(r + 3) & 3];
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
		return {mix_col(s[127:96], inv), mix_col(s[95:64], inv),
			mix_col(s[63:32], inv), mix_col(s[31:0], inv)};
	endfunction

endpackage

`default_nettype wire

// ===== src/aes_cbc_block_cipher.sv =====
// Top level of the AES-CBC block cipher.
// Depends on aes_cbc_pkg, aes_cbc_ctrl, aes_cbc_dp and aes_cbc_ram.
//
// Usage: program the key words, the key length, the IV and decrypt_mode through
// the write port (cfg_write, cfg_index, cfg_data) while the block is idle, then
// send 128-bit words on the input channel (in_valid, in_stall, block_high,
// block_low, first_block). Each input word gives one result word on the
// output channel (out_valid, out_stall, result_high, result_low). Set
// first_block on the first word of each message to reload the chain from
// the IV.
// Sequence: after the input word is taken, a load state, the initial
// AddRoundKey and Nr rounds (Nr = 10, 12 or 14) in the round state, and a
// finish state that registers the result. A new input word is taken only
// once the block is back in idle, as the single shared round unit and the
// CBC chain require. After reset or any key or key-length write, the first
// word also waits while the 4 * (Nr + 1) round key schedule words are
// generated, one schedule word per cycle. Reset clears the controller, the
// configuration, the chain and the key-valid flag, but not the data registers
// or the key store. While the receiver stalls, the held result stays put; the
// next word can still be computed and waits internally until the output register frees.
`default_nettype none

module aes_cbc_block_cipher
	import aes_cbc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [2:0] cfg_index,
	input wire logic [63:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [63:0] block_high,
	input wire logic [63:0] block_low,
	input wire logic first_block,
	output logic out_valid,
	input wire logic out_stall,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);

	cmd_t cmd;
	status_t status;

	aes_cbc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.cmd(cmd)
	);

	aes_cbc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.block_high(block_high),
		.block_low(block_low),
		.first_block(first_block),
		.cmd(cmd),
		.status(status),
		.result_high(result_high),
		.result_low(result_low)
	);

endmodule

`default_nettype wire

// ===== src/aes_cbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module aes_cbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/aes_cbc_ctrl.sv =====
// Controller of the AES-CBC block: key expansion sequencing, round counting
// and the input and output handshakes. Uses aes_cbc_pkg.
`default_nettype none

module aes_cbc_ctrl
	import aes_cbc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire status_t status,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXPAND = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [3:0] cnt_q;
	logic [5:0] widx_q;
	logic [2:0] mod_q;
	logic keys_ready_q;
	logic out_valid_q;

	logic accept;
	logic from_key;
	logic exp_last;
	logic out_free;
	logic [3:0] next_row;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept = in_valid && (state_q == ST_IDLE);
	assign from_key = (widx_q < {2'b00, status.nk});
	assign exp_last = (widx_q == {status.nr, 2'b11});
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		if (state_q == ST_LOAD) next_row = status.decrypt ? status.nr : 4'd0;
		else next_row = status.decrypt ? (status.nr - cnt_q - 4'd1) : (cnt_q + 4'd1);
	end

	always_comb begin
		cmd = '0;
		cmd.accept = accept;
		cmd.exp_en = (state_q == ST_EXPAND);
		cmd.exp_from_key = from_key;
		cmd.exp_idx = widx_q;
		cmd.exp_rot = !from_key && (mod_q == 3'd0);
		cmd.exp_sub = !from_key && (status.nk == 4'd8) && (mod_q == 3'd4);
		cmd.load = (state_q == ST_LOAD);
		cmd.op = (state_q != ST_ROUND) ? OP_NONE : ((cnt_q == 4'd0) ? OP_ARK : OP_ROUND);
		cmd.last = (cnt_q == status.nr);
		cmd.finish = (state_q == ST_FINISH) && out_free;
		cmd.rd_addr = RK_AW'(next_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			widx_q <= '0;
			mod_q <= '0;
			keys_ready_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			if (status.key_change) keys_ready_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					widx_q <= '0;
					mod_q <= '0;
					cnt_q <= '0;
					if (accept) state_q <= keys_ready_q ? ST_LOAD : ST_EXPAND;
				end
				ST_EXPAND: begin
					widx_q <= widx_q + 6'd1;
					mod_q <= ({1'b0, mod_q} == status.nk - 4'd1) ? 3'd0 : mod_q + 3'd1;
					if (exp_last) begin
						keys_ready_q <= 1'b1;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == status.nr) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_load_keys: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> keys_ready_q)
		else $error("cipher started without an expanded schedule");
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (cnt_q <= status.nr))
		else $error("round counter past the last round");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && !$past(cmd.finish)))
		else $error("held result word overwritten");

endmodule

`default_nettype wire

// ===== src/aes_cbc_dp.sv =====
// Datapath of the AES-CBC block: configuration registers, key schedule
// generation, round key store, round logic, chain and result registers.
// Uses aes_cbc_pkg and aes_cbc_ram.
`default_nettype none

module aes_cbc_dp
	import aes_cbc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_write,
	input wire logic [2:0] cfg_index,
	input wire logic [63:0] cfg_data,
	input wire logic [63:0] block_high,
	input wire logic [63:0] block_low,
	input wire logic first_block,
	input wire cmd_t cmd,
	output status_t status,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);

	logic [63:0] key_q [4];
	logic [1:0] key_size_q;
	logic [127:0] iv_q;
	logic decrypt_q;

	logic [127:0] blk_q;
	logic [127:0] chain_q;
	logic [127:0] state_q;
	logic [127:0] result_q;
	logic [31:0] win_q [8];
	logic [95:0] row_q;
	logic [7:0] rc_q;

	logic [3:0] nk;
	logic [31:0] sched_key;
	logic [31:0] w_back;
	logic [31:0] t;
	logic [31:0] new_word;
	logic [127:0] rk;
	logic [127:0] round_out;
	logic [127:0] ss;
	logic [127:0] dec_ark;

	assign nk = eff_nk(key_size_q);
	assign status.nk = nk;
	assign status.nr = nk + 4'd6;
	assign status.decrypt = decrypt_q;
	// A key write invalidates the schedule at the very edge that takes it.
	assign status.key_change = cfg_write
		&& (cfg_index inside {REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3, REG_KEY_LEN});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			key_size_q <= '0;
			iv_q <= '0;
			decrypt_q <= 1'b0;
			chain_q <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3: begin
						key_q[cfg_index[1:0]] <= cfg_data;
					end
					REG_KEY_LEN: begin
						key_size_q <= cfg_data[1:0];
					end
					REG_IV_HIGH: iv_q[127:64] <= cfg_data;
					REG_IV_LOW: iv_q[63:0] <= cfg_data;
					REG_DECRYPT_MODE: decrypt_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.accept && first_block) chain_q <= iv_q;
			else if (cmd.finish) chain_q <= decrypt_q ? blk_q : state_q;
		end
	end

	// Key schedule, one word per cycle, with the last eight words kept.
	assign sched_key = cmd.exp_idx[0] ? key_q[cmd.exp_idx[2:1]][31:0]
		: key_q[cmd.exp_idx[2:1]][63:32];

	always_comb begin
		case (nk)
			4'd4: w_back = win_q[3];
			4'd6: w_back = win_q[5];
			default: w_back = win_q[7];
		endcase
		t = win_q[0];
		if (cmd.exp_rot) t = sbox_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rc_q, 24'h0};
		else if (cmd.exp_sub) t = sbox_word(win_q[0]);
		new_word = cmd.exp_from_key ? sched_key : (w_back ^ t);
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_en) begin
			win_q[0] <= new_word;
			for (int i = 1; i < 8; i++) win_q[i] <= win_q[i - 1];
			case (cmd.exp_idx[1:0])
				2'd0: row_q[95:64] <= new_word;
				2'd1: row_q[63:32] <= new_word;
				2'd2: row_q[31:0] <= new_word;
				default: ;
			endcase
			if (cmd.exp_from_key) rc_q <= RCON_FIRST;
			else if (cmd.exp_rot) rc_q <= xt(rc_q);
		end
	end

	aes_cbc_ram #(
		.WIDTH(128),
		.DEPTH(RK_ROWS)
	) u_rk_ram (
		.clk(clk),
		.we(cmd.exp_en && (cmd.exp_idx[1:0] == 2'd3)),
		.waddr(RK_AW'(cmd.exp_idx[5:2])),
		.wdata({row_q, new_word}),
		.raddr(cmd.rd_addr),
		.rdata(rk)
	);

	// One round per cycle.
	always_comb begin
		ss = sub_shift(state_q, decrypt_q);
		dec_ark = ss ^ rk;
		if (cmd.op == OP_ARK) round_out = state_q ^ rk;
		else if (decrypt_q) round_out = cmd.last ? dec_ark : mix_cols(dec_ark, 1'b1);
		else round_out = (cmd.last ? ss : mix_cols(ss, 1'b0)) ^ rk;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) blk_q <= {block_high, block_low};
		if (cmd.load) state_q <= decrypt_q ? blk_q : (blk_q ^ chain_q);
		else if (cmd.op != OP_NONE) state_q <= round_out;
		if (cmd.finish) result_q <= decrypt_q ? (state_q ^ chain_q) : state_q;
	end

	assign result_high = result_q[127:64];
	assign result_low = result_q[63:0];

endmodule

`default_nettype wire
